[hw/rtl/sphv_pkg.sv]
// Shared types, widths and register codes of the sphere view test.
package sphv_pkg;

  localparam int CoordW  = 20;  // Q12.8 coordinate
  localparam int RadW    = 19;  // Q11.8 radius, unsigned
  localparam int AxisW   = 16;  // Q2.14 axis component
  localparam int OffW    = 21;  // centre minus camera
  localparam int ProdW   = 37;  // offset times axis component
  localparam int DotW    = 39;  // sum of three products
  localparam int LimitW  = 20;
  localparam int FactorW = 16;

  localparam int CfgIndexW = 4;
  localparam int CfgDataW  = 60;

  // register codes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_CAMERA_POSITION = 4'd0,
    CFG_FRONT_AXIS      = 4'd1,
    CFG_UP_AXIS         = 4'd2,
    CFG_LEFT_AXIS       = 4'd3,
    CFG_NEAR_LIMIT      = 4'd4,
    CFG_FAR_LIMIT       = 4'd5,
    CFG_VIEW_SLOPE      = 4'd6,
    CFG_ASPECT_RATIO    = 4'd7
  } cfg_index_t;

  // reset values
  localparam logic [LimitW-1:0]  NearReset   = 20'd256;
  localparam logic [LimitW-1:0]  FarReset    = 20'd256000;
  localparam logic [FactorW-1:0] SlopeReset  = 16'd13573;
  localparam logic [FactorW-1:0] AspectReset = 16'd5461;

  // camera setup as seen by the pipeline
  typedef struct packed {
    logic [3*CoordW-1:0] cam;
    logic [3*AxisW-1:0]  front;
    logic [3*AxisW-1:0]  up;
    logic [3*AxisW-1:0]  left;
    logic [LimitW-1:0]   near;
    logic [LimitW-1:0]   far;
    logic [FactorW-1:0]  slope;
    logic [FactorW-1:0]  aspect;
  } cfg_t;

  // three projections of one sphere plus its radius
  typedef struct packed {
    logic signed [DotW-1:0] depth;
    logic signed [DotW-1:0] up;
    logic signed [DotW-1:0] lf;
    logic [RadW-1:0]        rad;
  } dot_t;

  function automatic logic signed [AxisW-1:0] axis_comp(input logic [3*AxisW-1:0] axis,
                                                        input int idx);
    axis_comp = $signed(axis[AxisW*idx +: AxisW]);
  endfunction

  function automatic logic signed [CoordW-1:0] cam_comp(input logic [3*CoordW-1:0] cam,
                                                        input int idx);
    cam_comp = $signed(cam[CoordW*idx +: CoordW]);
  endfunction

endpackage

[hw/rtl/sphere_view_frustum_test.sv]
// Top level of the sphere view-volume test: config registers and six-stage pipeline.
//
// channel  direction  signals                          word contents
// s_axis   in         s_tvalid s_tready s_tdata[79:0]  sphere centre x,y,z and radius
// m_axis   out        m_tvalid m_tready m_tdata[7:0]   in_view flag
// cfg      in         cfg_valid cfg_ready index data   one camera setup register
//
// One sphere is accepted per cycle while the output is not stalled; m_tvalid rises once
// the sphere has passed the six register stages (offset, products, sums, depth and height
// product, width product, final compare), with its result word.
// cfg_ready is always high.
// rst is synchronous: it empties the pipeline and restores the camera setup defaults.
// Each stage holds while the next is full and blocked, so bubbles are squeezed out and
// input is taken while a result waits at the output.
module sphere_view_frustum_test
  import sphv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [79:0]          s_tdata,    // center_x, center_y, center_z, sphere_radius, pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,    // in_view, pad
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cfg_t cfg;
  dot_t dots;
  logic dot_valid, dot_ready;
  logic in_view;

  sphv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // projection onto the camera axes
  sphv_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cx        ($signed(s_tdata[19:0])),
    .cy        ($signed(s_tdata[39:20])),
    .cz        ($signed(s_tdata[59:40])),
    .rad_in    (s_tdata[78:60]),
    .out_valid (dot_valid),
    .out_ready (dot_ready),
    .dots      (dots)
  );

  // plane tests
  sphv_cull u_cull (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (dot_valid),
    .in_ready  (dot_ready),
    .dots      (dots),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .in_view   (in_view)
  );

  assign m_tdata = {7'b0, in_view};

`ifndef SYNTH
  // with the output stage empty nothing can block the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");

  // reset leaves no result behind
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present right after reset");
`endif

endmodule

[hw/rtl/sphv_cfg.sv]
// Camera setup register file written over the configuration channel.
module sphv_cfg
  import sphv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  // register writes, unknown codes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cam    <= '0;
      cfg.front  <= '0;
      cfg.up     <= '0;
      cfg.left   <= '0;
      cfg.near   <= NearReset;
      cfg.far    <= FarReset;
      cfg.slope  <= SlopeReset;
      cfg.aspect <= AspectReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAMERA_POSITION: cfg.cam    <= cfg_data[3*CoordW-1:0];
        CFG_FRONT_AXIS:      cfg.front  <= cfg_data[3*AxisW-1:0];
        CFG_UP_AXIS:         cfg.up     <= cfg_data[3*AxisW-1:0];
        CFG_LEFT_AXIS:       cfg.left   <= cfg_data[3*AxisW-1:0];
        CFG_NEAR_LIMIT:      cfg.near   <= cfg_data[LimitW-1:0];
        CFG_FAR_LIMIT:       cfg.far    <= cfg_data[LimitW-1:0];
        CFG_VIEW_SLOPE:      cfg.slope  <= cfg_data[FactorW-1:0];
        CFG_ASPECT_RATIO:    cfg.aspect <= cfg_data[FactorW-1:0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/sphv_dot.sv]
// Offset, product and sum stages: projects the sphere centre onto the camera axes.
module sphv_dot
  import sphv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CoordW-1:0] cx,
  input  logic signed [CoordW-1:0] cy,
  input  logic signed [CoordW-1:0] cz,
  input  logic [RadW-1:0]          rad_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output dot_t                     dots
);

  logic                   va, vb, vc;
  logic                   rdy_a, rdy_b, rdy_c;
  logic signed [OffW-1:0] off_a [3];
  logic [RadW-1:0]        rad_a, rad_b;
  logic signed [ProdW-1:0] prod_b [3][3];  // [axis][component]
  logic [2:0][3*AxisW-1:0] axes;
  logic signed [CoordW-1:0] cen [3];

  assign axes = {cfg.left, cfg.up, cfg.front};
  assign cen[0] = cx;
  assign cen[1] = cy;
  assign cen[2] = cz;

  // a stage moves when it is empty or the next one takes its word
  assign rdy_c    = !vc || out_ready;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
    end
  end

  // stage A: centre minus camera position
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      for (int i = 0; i < 3; i++) begin
        off_a[i] <= OffW'(cen[i]) - OffW'(cam_comp(cfg.cam, i));
      end
      rad_a <= rad_in;
    end
  end

  // stage B: nine products
  always_ff @(posedge clk) begin
    if (rdy_b) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          prod_b[k][i] <= ProdW'(off_a[i]) * ProdW'(axis_comp(axes[k], i));
        end
      end
      rad_b <= rad_a;
    end
  end

  // stage C: dot product sums
  always_ff @(posedge clk) begin
    if (rdy_c) begin
      dots.depth <= DotW'(prod_b[0][0]) + DotW'(prod_b[0][1]) + DotW'(prod_b[0][2]);
      dots.up    <= DotW'(prod_b[1][0]) + DotW'(prod_b[1][1]) + DotW'(prod_b[1][2]);
      dots.lf    <= DotW'(prod_b[2][0]) + DotW'(prod_b[2][1]) + DotW'(prod_b[2][2]);
      dots.rad   <= rad_b;
    end
  end

  assign out_valid = vc;

endmodule

[hw/rtl/sphv_cull.sv]
// Depth, vertical and horizontal test stages; the last stage is the output register.
module sphv_cull
  import sphv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  dot_t dots,
  output logic out_valid,
  input  logic out_ready,
  output logic in_view
);

  localparam int HProdW = DotW + FactorW + 1;   // 56
  localparam int HW     = HProdW - 14;          // 42, height in 2^-22
  localparam int WProdW = HW + FactorW + 1;     // 59
  localparam int WW     = WProdW - 12;          // 47, width in 2^-22
  localparam int DSumW  = DotW + 2;             // 41
  localparam int UpCmpW = HW + 3;               // 45
  localparam int LfCmpW = WW + 2;               // 49

  logic vd, ve, vf;
  logic rdy_d, rdy_e, rdy_f;

  logic                     ok_d, ok_e, in_view_f;
  logic signed [HProdW-1:0] hprod_d;
  logic signed [DotW-1:0]   up_d, lf_d, lf_e;
  logic [RadW-1:0]          rad_d, rad_e;
  logic signed [WProdW-1:0] wprod_e;

  logic signed [DSumW-1:0]  dsum, far22, near22;
  logic signed [HW-1:0]     h_d;
  logic signed [UpCmpW-1:0] up_o2, up_hi;
  logic                     up_ok;
  logic signed [WW-1:0]     w_e;
  logic signed [LfCmpW-1:0] lf_o2, lf_hi;
  logic                     lf_ok;

  assign rdy_f    = !vf || out_ready;
  assign rdy_e    = !ve || rdy_f;
  assign rdy_d    = !vd || rdy_e;
  assign in_ready = rdy_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
    end else begin
      if (rdy_d) vd <= in_valid;
      if (rdy_e) ve <= vd;
      if (rdy_f) vf <= ve;
    end
  end

  // depth window: near <= depth + radius <= far, all in 2^-22
  always_comb begin
    dsum   = DSumW'(dots.depth) + $signed({8'b0, dots.rad, 14'b0});
    far22  = $signed({7'b0, cfg.far, 14'b0});
    near22 = $signed({7'b0, cfg.near, 14'b0});
  end

  // stage D: depth test and height product
  always_ff @(posedge clk) begin
    if (rdy_d) begin
      ok_d    <= (dsum <= far22) && (dsum >= near22);
      hprod_d <= dots.depth * $signed({1'b0, cfg.slope});
      up_d    <= dots.up;
      lf_d    <= dots.lf;
      rad_d   <= dots.rad;
    end
  end

  // vertical test; the arithmetic shift floors the height
  always_comb begin
    h_d   = hprod_d[HProdW-1:14];
    up_o2 = $signed({{(UpCmpW-DotW-1){up_d[DotW-1]}}, up_d, 1'b0});
    up_hi = UpCmpW'(h_d) + $signed({{(UpCmpW-RadW-15){1'b0}}, rad_d, 15'b0});
    up_ok = !(up_o2 > up_hi) && !((up_o2 + up_hi) < UpCmpW'(0));
  end

  // stage E: vertical result and width product
  always_ff @(posedge clk) begin
    if (rdy_e) begin
      ok_e    <= ok_d && up_ok;
      wprod_e <= h_d * $signed({1'b0, cfg.aspect});
      lf_e    <= lf_d;
      rad_e   <= rad_d;
    end
  end

  // horizontal test on the floored width
  always_comb begin
    w_e   = wprod_e[WProdW-1:12];
    lf_o2 = $signed({{(LfCmpW-DotW-1){lf_e[DotW-1]}}, lf_e, 1'b0});
    lf_hi = LfCmpW'(w_e) + $signed({{(LfCmpW-RadW-15){1'b0}}, rad_e, 15'b0});
    lf_ok = !(lf_o2 > lf_hi) && !((lf_o2 + lf_hi) < LfCmpW'(0));
  end

  // stage F: output register
  always_ff @(posedge clk) begin
    if (rdy_f) begin
      in_view_f <= ok_e && lf_ok;
    end
  end

  assign out_valid = vf;
  assign in_view   = in_view_f;

`ifndef SYNTH
  // a word taken out of stage D lands in stage E
  a_d_to_e: assert property (@(posedge clk) disable iff (rst)
    vd && rdy_e |=> ve)
    else $error("word lost between stage D and stage E");

  // an earlier rejection always reaches the output as a miss
  a_reject_kept: assert property (@(posedge clk) disable iff (rst)
    ve && !ok_e && rdy_f |=> vf && !in_view_f)
    else $error("rejected sphere reported in view");
`endif

endmodule

[tb/sv/sphere_view_checker.sv]
`timescale 1ns / 1ps
// Checker for the sphere view-volume test: tracks camera setup, predicts and compares in_view.
module sphere_view_checker
  import sphv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [79:0]          s_tdata,    // center_x, center_y, center_z, sphere_radius, pad
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [7:0]           m_tdata,    // in_view, pad
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output int                   errors,
  output int                   pending
);

  cfg_t camera_setup;
  logic expected_in_view[$];

  // signed projection of an offset onto one packed Q2.14 axis, 2^-22 units
  function automatic longint axis_dot(input longint ox, input longint oy, input longint oz,
                                      input logic [3*AxisW-1:0] axis);
    axis_dot = ox * longint'($signed(axis[AxisW-1:0]))
             + oy * longint'($signed(axis[2*AxisW-1:AxisW]))
             + oz * longint'($signed(axis[3*AxisW-1:2*AxisW]));
  endfunction

  // both-sided slab test: twice the offset against span plus twice the radius
  function automatic bit in_slab(input longint offset, input longint span, input longint rad);
    in_slab = !((2 * offset > span + 2 * rad) || (2 * offset < -span - 2 * rad));
  endfunction

  function automatic logic predict_in_view(input cfg_t setup, input logic [79:0] word);
    longint ox, oy, oz, rad22, depth, height, width;
    ox = longint'($signed(word[CoordW-1:0])) - longint'($signed(setup.cam[CoordW-1:0]));
    oy = longint'($signed(word[2*CoordW-1:CoordW]))
       - longint'($signed(setup.cam[2*CoordW-1:CoordW]));
    oz = longint'($signed(word[3*CoordW-1:2*CoordW]))
       - longint'($signed(setup.cam[3*CoordW-1:2*CoordW]));
    rad22 = longint'(word[3*CoordW+RadW-1:3*CoordW]) <<< 14;

    // depth against near and far
    depth = axis_dot(ox, oy, oz, setup.front);
    if (depth + rad22 > longint'(setup.far) * 16384 ||
        depth + rad22 < longint'(setup.near) * 16384)
      return 1'b0;

    // vertical, height floored to 2^-22
    height = (depth * longint'(setup.slope)) >>> 14;
    if (!in_slab(axis_dot(ox, oy, oz, setup.up), height, rad22))
      return 1'b0;

    // horizontal, width floored to 2^-22
    width = (height * longint'(setup.aspect)) >>> 12;
    return in_slab(axis_dot(ox, oy, oz, setup.left), width, rad22);
  endfunction

  always @(posedge clk) begin : track
    logic want;
    if (rst) begin
      camera_setup <= '{cam: '0, front: '0, up: '0, left: '0, near: NearReset,
                        far: FarReset, slope: SlopeReset, aspect: AspectReset};
      expected_in_view.delete();
      errors = 0;
      pending <= 0;
    end else begin
      // result word against the oldest prediction
      if (m_tvalid && m_tready) begin
        if (expected_in_view.size() == 0) begin
          $display("%0t: unexpected in_view word, expected none, got %0b", $time, m_tdata[0]);
          errors = errors + 1;
        end else begin
          want = expected_in_view.pop_front();
          if (m_tdata[0] !== want) begin
            $display("%0t: in_view mismatch, expected %0b, got %0b", $time, want, m_tdata[0]);
            errors = errors + 1;
          end
        end
      end

      // sphere word: predict with the setup in force now
      if (s_tvalid && s_tready)
        expected_in_view.push_back(predict_in_view(camera_setup, s_tdata));

      // register writes, unknown indexes ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAMERA_POSITION: camera_setup.cam    <= cfg_data[3*CoordW-1:0];
          CFG_FRONT_AXIS:      camera_setup.front  <= cfg_data[3*AxisW-1:0];
          CFG_UP_AXIS:         camera_setup.up     <= cfg_data[3*AxisW-1:0];
          CFG_LEFT_AXIS:       camera_setup.left   <= cfg_data[3*AxisW-1:0];
          CFG_NEAR_LIMIT:      camera_setup.near   <= cfg_data[LimitW-1:0];
          CFG_FAR_LIMIT:       camera_setup.far    <= cfg_data[LimitW-1:0];
          CFG_VIEW_SLOPE:      camera_setup.slope  <= cfg_data[FactorW-1:0];
          CFG_ASPECT_RATIO:    camera_setup.aspect <= cfg_data[FactorW-1:0];
          default: ;
        endcase
      end

      pending <= expected_in_view.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the sphere view-volume test.
module testbench;
  import sphv_pkg::*;

  localparam int LimitCycles    = 1000000;
  localparam int DrainCycles    = 24;
  localparam int RandomPerPhase = 250;
  localparam int NumPhases      = 8;
  localparam logic [CfgIndexW-1:0] CfgFirstUnused = 4'd8;
  localparam logic signed [AxisW-1:0] AxisOne = 16'sd16384;
  localparam longint CoordMax = 524287;
  localparam longint CoordMin = -524288;
  localparam longint RadMax   = 524287;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic [79:0]          s_tdata = '0;
  logic                 m_tready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 s_tready;
  logic                 m_tvalid;
  logic [7:0]           m_tdata;
  logic                 cfg_ready;

  int errors;
  int pending;
  int cycle_count = 0;
  int ready_hold = 0;
  bit quiet = 1'b0;  // no idling on either side

  // camera frame used to aim shaped spheres
  int cam_c[3];
  int front_i, up_i, left_i;
  int front_s, up_s, left_s;
  longint slope_v, aspect_v;

  always #2 clk = ~clk;

  sphere_view_frustum_test dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sphere_view_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int idle_length();
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(99);
    if (r < 60)
      return 0;
    if (r < 93)
      return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver stalls
  always @(posedge clk) begin : ready_gen
    int low;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      low = idle_length();
      if (low > 0) begin
        m_tready <= 1'b0;
        ready_hold <= low - 1;
      end else begin
        m_tready <= 1'b1;
        ready_hold <= quiet ? 0 : $urandom_range(7);
      end
    end
  end

  function automatic logic [79:0] pack_sphere(input longint x, input longint y,
                                              input longint z, input longint r);
    pack_sphere = {1'b0, r[RadW-1:0], z[CoordW-1:0], y[CoordW-1:0], x[CoordW-1:0]};
  endfunction

  function automatic logic [3*AxisW-1:0] unit_axis(input int idx, input int sgn);
    logic [3*AxisW-1:0] a;
    a = '0;
    a[AxisW*idx +: AxisW] = (sgn < 0) ? -AxisOne : AxisOne;
    return a;
  endfunction

  function automatic logic [3*CoordW-1:0] cam_word();
    cam_word = {cam_c[2][CoordW-1:0], cam_c[1][CoordW-1:0], cam_c[0][CoordW-1:0]};
  endfunction

  // register write; bits above the register width carry junk
  task automatic cfg_write(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value,
                           input int width);
    logic [CfgDataW-1:0] word;
    word = CfgDataW'({$urandom, $urandom});
    if (width < CfgDataW)
      word = ((word >> width) << width) | value;
    else
      word = value;
    cfg_index <= idx;
    cfg_data <= word;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
  endtask

  // full camera setup, written once the pipeline has drained
  task automatic load_setup(input logic [3*CoordW-1:0] cam_w, input logic [3*AxisW-1:0] front_w,
                            input logic [3*AxisW-1:0] up_w, input logic [3*AxisW-1:0] left_w,
                            input logic [LimitW-1:0] near_w, input logic [LimitW-1:0] far_w,
                            input logic [FactorW-1:0] slope_w,
                            input logic [FactorW-1:0] aspect_w);
    wait_idle();
    cfg_write(CfgIndexW'(CfgFirstUnused + $urandom_range(7)), '1, CfgDataW);
    cfg_write(CFG_CAMERA_POSITION, cam_w, 3 * CoordW);
    cfg_write(CFG_FRONT_AXIS, front_w, 3 * AxisW);
    cfg_write(CFG_UP_AXIS, up_w, 3 * AxisW);
    cfg_write(CFG_LEFT_AXIS, left_w, 3 * AxisW);
    cfg_write(CFG_NEAR_LIMIT, near_w, LimitW);
    cfg_write(CFG_FAR_LIMIT, far_w, LimitW);
    cfg_write(CFG_VIEW_SLOPE, slope_w, FactorW);
    cfg_write(CFG_ASPECT_RATIO, aspect_w, FactorW);
    cfg_valid <= 1'b0;
    slope_v = slope_w;
    aspect_v = aspect_w;
  endtask

  // axis-aligned frame with random permutation and signs, camera near the origin
  task automatic pick_frame();
    front_i = $urandom_range(2);
    up_i = (front_i + 1 + $urandom_range(1)) % 3;
    left_i = 3 - front_i - up_i;
    front_s = $urandom_range(1) ? 1 : -1;
    up_s = $urandom_range(1) ? 1 : -1;
    left_s = $urandom_range(1) ? 1 : -1;
    for (int i = 0; i < 3; i++)
      cam_c[i] = int'($urandom_range(200000)) - 100000;
  endtask

  task automatic send_sphere(input logic [79:0] word);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= word;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // mostly spheres aimed around the view volume edges, some raw noise
  task automatic random_sphere();
    longint d, rad, hh, hw, u, l, span_u, span_l;
    longint c[3];
    if ($urandom_range(4) == 0) begin
      send_sphere({1'b0, 19'($urandom), 30'($urandom), 30'($urandom)});
    end else begin
      d = longint'($urandom_range(300000)) - 2000;
      rad = ($urandom_range(9) == 0) ? longint'($urandom_range(RadMax))
                                     : longint'($urandom_range(4000));
      hh = (d * slope_v) >>> 15;
      hw = (hh * aspect_v) >>> 12;
      span_u = ((hh < 0 ? -hh : hh) + rad) * 5 / 4 + 16;
      span_l = ((hw < 0 ? -hw : hw) + rad) * 5 / 4 + 16;
      u = longint'($urandom_range(32'(2 * span_u))) - span_u;
      l = longint'($urandom_range(32'(2 * span_l))) - span_l;
      for (int i = 0; i < 3; i++)
        c[i] = cam_c[i];
      c[front_i] += front_s * d;
      c[up_i] += up_s * u;
      c[left_i] += left_s * l;
      send_sphere(pack_sphere(c[0], c[1], c[2], rad));
    end
  endtask

  initial begin
    int near_r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset setup: zero axes, only the radius against near and far matters
    send_sphere(pack_sphere(CoordMin, CoordMax, 0, 0));
    send_sphere(pack_sphere(CoordMax, CoordMin, 1, 255));
    send_sphere(pack_sphere(0, 0, 0, 256));
    send_sphere(pack_sphere(0, 0, 0, 257));
    send_sphere(pack_sphere(12345, -777, 3, 256000));
    send_sphere(pack_sphere(0, 0, 0, 256001));
    send_sphere(pack_sphere(-1, -1, -1, RadMax));

    // plain frame: front x, up y, left z, camera at the origin
    front_i = 0; up_i = 1; left_i = 2;
    front_s = 1; up_s = 1; left_s = 1;
    cam_c[0] = 0; cam_c[1] = 0; cam_c[2] = 0;
    load_setup(cam_word(), unit_axis(0, 1), unit_axis(1, 1), unit_axis(2, 1),
               NearReset, FarReset, SlopeReset, AspectReset);
    send_sphere(pack_sphere(10000, 0, 0, 0));
    send_sphere(pack_sphere(-10000, 0, 0, 100));        // behind the camera
    send_sphere(pack_sphere(-1000, 0, 0, 20000));       // behind, saved by the radius
    send_sphere(pack_sphere(CoordMax, CoordMax, CoordMax, RadMax));
    send_sphere(pack_sphere(CoordMin, CoordMin, CoordMin, 0));
    send_sphere(pack_sphere(CoordMax, 0, 0, 0));         // beyond far
    send_sphere(pack_sphere(200, 0, 0, 56));             // touches near exactly
    send_sphere(pack_sphere(100000, 41418, 0, 0));       // around the top edge
    send_sphere(pack_sphere(100000, 41430, 0, 0));
    send_sphere(pack_sphere(100000, -41430, 0, 0));
    send_sphere(pack_sphere(100000, 0, 55220, 0));       // around the side edges
    send_sphere(pack_sphere(100000, 0, -56000, 0));
    send_sphere(pack_sphere(0, 0, 0, 300));              // centred on the camera

    // random phases over several setups
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin
          pick_frame();
          load_setup(cam_word(), unit_axis(front_i, front_s), unit_axis(up_i, up_s),
                     unit_axis(left_i, left_s), NearReset, FarReset, SlopeReset, AspectReset);
        end
        1: begin
          pick_frame();
          near_r = $urandom_range(20000);
          load_setup(cam_word(), unit_axis(front_i, front_s), unit_axis(up_i, up_s),
                     unit_axis(left_i, left_s), LimitW'(near_r),
                     LimitW'(near_r + $urandom_range(400000)),
                     FactorW'($urandom), FactorW'($urandom));
        end
        2: begin
          // largest magnitudes everywhere
          pick_frame();
          for (int i = 0; i < 3; i++)
            cam_c[i] = int'(CoordMax);
          load_setup(cam_word(), {3{16'h8000}}, {3{16'h8000}}, {3{16'h7fff}},
                     '0, '1, '1, '1);
        end
        3: begin
          // zero slope and aspect, camera at the lowest corner
          pick_frame();
          for (int i = 0; i < 3; i++)
            cam_c[i] = int'(CoordMin);
          load_setup(cam_word(), unit_axis(front_i, front_s), unit_axis(up_i, up_s),
                     unit_axis(left_i, left_s), '0, '1, '0, '0);
        end
        4, 7: begin
          pick_frame();
          for (int i = 0; i < 3; i++)
            cam_c[i] = int'($urandom_range(1048575)) - 524288;
          load_setup(cam_word(), 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), LimitW'($urandom), LimitW'($urandom),
                     FactorW'($urandom), FactorW'($urandom));
          if (phase == 7)
            quiet <= 1'b1;
        end
        5: begin
          // near beyond far: nothing can pass
          pick_frame();
          load_setup(cam_word(), unit_axis(front_i, front_s), unit_axis(up_i, up_s),
                     unit_axis(left_i, left_s), FarReset, NearReset, SlopeReset, AspectReset);
        end
        default: begin
          pick_frame();
          load_setup(cam_word(), unit_axis(front_i, front_s), unit_axis(up_i, up_s),
                     unit_axis(left_i, left_s), NearReset, '1, '1, '1);
        end
      endcase
      repeat (RandomPerPhase) random_sphere();
    end

    // drain and verdict
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
